[hdl/shabs_pkg.sv]
// Shared types, constants and helper functions of the byte-serial SHA-256 hasher.
// No dependencies; imported by shabs_core, sha256_byte_stream_hasher and the testbench.
`timescale 1ns / 1ps
package shabs_pkg;

	// Command codes carried on the input tuser
	localparam logic [1:0] CMD_DATA = 2'd0;
	localparam logic [1:0] CMD_LAST = 2'd1;
	localparam logic [1:0] CMD_END  = 2'd2;

	localparam int BLOCK_WORDS = 16;
	localparam int HASH_WORDS  = 8;
	localparam int ROUNDS      = 64;

	localparam logic [31:0] H_INIT [HASH_WORDS] = '{
		32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
		32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
	};

	localparam logic [31:0] K_TAB [ROUNDS] = '{
		32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
		32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
		32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
		32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
		32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
		32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
		32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
		32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
		32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
		32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
		32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
		32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
		32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
		32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
		32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
		32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
	};

	// Control from the sequencer to the compression engine
	typedef struct packed {
		logic start;   // load block and working words, run 64 rounds
		logic init;    // return hash words to the initial values
	} shabs_ctl_t;

	// Status from the compression engine
	typedef struct packed {
		logic done;    // feed-forward add happens at this edge
	} shabs_sts_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] big_sig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] big_sig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

	function automatic logic [31:0] sml_sig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sml_sig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

endpackage

[hdl/shabs_core.sv]
// SHA-256 compression engine: one round per cycle over a rolling 16-word schedule.
// Depends on shabs_pkg (round constants, initial hash, sigma functions, control types).
`timescale 1ns / 1ps
module shabs_core
	import shabs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  shabs_ctl_t             ctl,
	input  logic [15:0][31:0]      blk,
	output shabs_sts_t             sts,
	output logic [7:0][31:0]       hash
);

	localparam logic [1:0] C_IDLE = 2'd0;
	localparam logic [1:0] C_RND  = 2'd1;
	localparam logic [1:0] C_ADD  = 2'd2;

	logic [1:0]        state_q;
	logic [5:0]        rnd_q;
	logic [15:0][31:0] w_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [7:0][31:0]  hw_q;

	logic [31:0] t1, t2, w_new;

	always_comb begin
		t1 = h_q + big_sig1(e_q) + ((e_q & f_q) ^ (~e_q & g_q)) + K_TAB[rnd_q] + w_q[0];
		t2 = big_sig0(a_q) + ((a_q & b_q) ^ (a_q & c_q) ^ (b_q & c_q));
		w_new = w_q[0] + sml_sig0(w_q[1]) + w_q[9] + sml_sig1(w_q[14]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			for (int i = 0; i < HASH_WORDS; i++) begin
				hw_q[i] <= H_INIT[i];
			end
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctl.start) begin
						state_q <= C_RND;
						rnd_q   <= '0;
					end
					if (ctl.init) begin
						for (int i = 0; i < HASH_WORDS; i++) begin
							hw_q[i] <= H_INIT[i];
						end
					end
				end
				C_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(ROUNDS - 1)) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					// feed-forward add into the chaining words
					hw_q[0] <= hw_q[0] + a_q;
					hw_q[1] <= hw_q[1] + b_q;
					hw_q[2] <= hw_q[2] + c_q;
					hw_q[3] <= hw_q[3] + d_q;
					hw_q[4] <= hw_q[4] + e_q;
					hw_q[5] <= hw_q[5] + f_q;
					hw_q[6] <= hw_q[6] + g_q;
					hw_q[7] <= hw_q[7] + h_q;
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// working words and schedule window carry no reset
	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && ctl.start) begin
			w_q <= blk;
			a_q <= hw_q[0];
			b_q <= hw_q[1];
			c_q <= hw_q[2];
			d_q <= hw_q[3];
			e_q <= hw_q[4];
			f_q <= hw_q[5];
			g_q <= hw_q[6];
			h_q <= hw_q[7];
		end else if (state_q == C_RND) begin
			h_q <= g_q;
			g_q <= f_q;
			f_q <= e_q;
			e_q <= d_q + t1;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= a_q;
			a_q <= t1 + t2;
			for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
				w_q[i] <= w_q[i + 1];
			end
			w_q[BLOCK_WORDS - 1] <= w_new;
		end
	end

	assign sts.done = (state_q == C_ADD);
	assign hash     = hw_q;

endmodule

[hdl/sha256_byte_stream_hasher.sv]
// Top level of the byte-serial SHA-256 hasher: byte packing, padding sequencer,
// digest output buffer. Depends on shabs_pkg and instantiates shabs_core.
`timescale 1ns / 1ps
//
//  Channel  | Direction | Signals                          | Contents
//  ---------+-----------+----------------------------------+-------------------------------
//  s_*      | in        | s_tvalid s_tready s_tdata s_tuser | one message byte and command
//  m_*      | out       | m_tvalid m_tready m_tdata m_tlast | one digest word, H0 first
//
//  A byte that does not complete a 64-byte block is taken without a stall; one that
//  completes it holds s_tready low through the compression (start, 64 rounds, feed-forward
//  add in shabs_core). Ending a message takes a padding step, a compression and a digest
//  load, plus a length step and a second compression when 56 or more bytes sit in
//  the last block. Reset restores the initial hash words and empties block and buffer.
//  A stalled m_tready holds off input only when a new digest waits on the old one.
module sha256_byte_stream_hasher
	import shabs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [1:0]  s_tuser,   // [1:0] command
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic        m_tlast    // last_word
);

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_COMP = 3'd1;
	localparam logic [2:0] T_PAD  = 3'd2;
	localparam logic [2:0] T_LEN  = 3'd3;
	localparam logic [2:0] T_OUT  = 3'd4;

	logic [2:0]        state_q;
	logic [2:0]        ret_q;      // state to resume after a compression
	logic              start_q;
	logic [5:0]        fill_q;
	logic [60:0]       len_q;
	logic [15:0][31:0] blk_q;
	logic [7:0][31:0]  ob_q;
	logic [3:0]        ob_cnt_q;

	shabs_ctl_t        ctl;
	shabs_sts_t        sts;
	logic [7:0][31:0]  hash;

	logic              s_acc, m_acc, ob_load, byte_acc;
	logic [3:0]        wi;
	logic [1:0]        lane;
	logic [31:0]       byte_word, pad_word;
	logic [63:0]       bit_len;

	assign s_tready = (state_q == T_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign byte_acc = s_acc && (s_tuser == CMD_DATA || s_tuser == CMD_LAST);
	assign m_acc    = m_tvalid && m_tready;
	assign ob_load  = (state_q == T_OUT) && (ob_cnt_q == 4'd0);

	assign wi      = fill_q[5:2];
	assign lane    = fill_q[1:0];
	assign bit_len = {len_q, 3'b000};

	// insert the byte big-endian; lane 0 clears the rest of the word
	always_comb begin
		case (lane)
			2'd0:    byte_word = {s_tdata, 24'h0};
			2'd1:    byte_word = {blk_q[wi][31:24], s_tdata, blk_q[wi][15:0]};
			2'd2:    byte_word = {blk_q[wi][31:16], s_tdata, blk_q[wi][7:0]};
			default: byte_word = {blk_q[wi][31:8], s_tdata};
		endcase
	end

	// keep message bytes, place the 0x80 marker, zero what follows
	always_comb begin
		case (lane)
			2'd0:    pad_word = 32'h8000_0000;
			2'd1:    pad_word = {blk_q[wi][31:24], 8'h80, 16'h0};
			2'd2:    pad_word = {blk_q[wi][31:16], 8'h80, 8'h0};
			default: pad_word = {blk_q[wi][31:8], 8'h80};
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			ret_q   <= T_IDLE;
			start_q <= 1'b0;
			fill_q  <= '0;
			len_q   <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				T_IDLE: begin
					if (byte_acc) begin
						fill_q <= fill_q + 6'd1;
						len_q  <= len_q + 61'd1;
						if (fill_q == 6'd63) begin
							// block full: compress, then pad if this byte ends it
							start_q <= 1'b1;
							state_q <= T_COMP;
							ret_q   <= (s_tuser == CMD_LAST) ? T_PAD : T_IDLE;
						end else if (s_tuser == CMD_LAST) begin
							state_q <= T_PAD;
						end
					end else if (s_acc && s_tuser == CMD_END) begin
						state_q <= T_PAD;
					end
				end
				T_COMP: begin
					if (sts.done) begin
						state_q <= ret_q;
					end
				end
				T_PAD: begin
					start_q <= 1'b1;
					state_q <= T_COMP;
					// no room for the length: it goes into an extra block
					ret_q   <= (fill_q[5:3] == 3'b111) ? T_LEN : T_OUT;
				end
				T_LEN: begin
					start_q <= 1'b1;
					state_q <= T_COMP;
					ret_q   <= T_OUT;
				end
				T_OUT: begin
					// wait for the buffer to drain, then start a fresh message
					if (ob_cnt_q == 4'd0) begin
						fill_q  <= '0;
						len_q   <= '0;
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	// block words
	always_ff @(posedge clk) begin
		if (state_q == T_IDLE && byte_acc) begin
			blk_q[wi] <= byte_word;
		end else if (state_q == T_PAD) begin
			for (int i = 0; i < BLOCK_WORDS; i++) begin
				if (4'(i) == wi) begin
					blk_q[i] <= pad_word;
				end else if (4'(i) > wi) begin
					blk_q[i] <= 32'h0;
				end
			end
			if (fill_q[5:3] != 3'b111) begin
				blk_q[14] <= bit_len[63:32];
				blk_q[15] <= bit_len[31:0];
			end
		end else if (state_q == T_LEN) begin
			for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
				blk_q[i] <= 32'h0;
			end
			blk_q[14] <= bit_len[63:32];
			blk_q[15] <= bit_len[31:0];
		end
	end

	// digest output buffer: load all eight words, shift one out per word taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_cnt_q <= '0;
		end else if (ob_load) begin
			ob_cnt_q <= 4'd8;
		end else if (m_acc) begin
			ob_cnt_q <= ob_cnt_q - 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ob_load) begin
			ob_q <= hash;
		end else if (m_acc) begin
			for (int i = 0; i < HASH_WORDS - 1; i++) begin
				ob_q[i] <= ob_q[i + 1];
			end
		end
	end

	assign m_tvalid = (ob_cnt_q != 4'd0);
	assign m_tdata  = ob_q[0];
	assign m_tlast  = (ob_cnt_q == 4'd1);

	assign ctl.start = start_q;
	assign ctl.init  = ob_load;

	shabs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.blk    (blk_q),
		.sts    (sts),
		.hash   (hash)
	);

endmodule

[test/testbench.sv]
// Self-checking testbench for sha256_byte_stream_hasher: random byte messages with random
// gaps and stalls, digests predicted by an independent SHA-256 model in a scoreboard.
// Depends on shabs_pkg (command codes) and the RTL of the hasher.
`timescale 1ns / 1ps

typedef struct packed {
	logic [31:0] word;
	logic        last;
} digest_entry_t;

class digest_scoreboard;
	logic [31:0]   round_k [64];
	logic [31:0]   iv [8];
	logic [31:0]   chain [8];
	logic [31:0]   msg_blk [16];
	logic [5:0]    blk_fill;
	logic [60:0]   byte_count;
	digest_entry_t pending_digest [$];
	int            fails;

	function new();
		round_k = '{
			32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
			32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
			32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
			32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
			32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
			32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
			32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
			32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
			32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
			32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
			32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
			32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
			32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
			32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
			32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
			32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
		};
		iv = '{
			32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
			32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
		};
		fails = 0;
		restart();
	endfunction

	function void restart();
		int i;
		chain = iv;
		for (i = 0; i < 16; i++)
			msg_blk[i] = '0;
		blk_fill   = '0;
		byte_count = '0;
	endfunction

	function logic [31:0] ror(logic [31:0] x, int n);
		logic [63:0] twice;
		twice = {x, x};
		return twice[n +: 32];
	endfunction

	function void compress_block();
		logic [31:0] w [64];
		logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
		int i;
		for (i = 0; i < 16; i++)
			w[i] = msg_blk[i];
		for (i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
		e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
		for (i = 0; i < 64; i++) begin
			t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
				+ round_k[i] + w[i];
			t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
			h = g; g = f; f = e; e = d + t1;
			d = c; c = b; b = a; a = t1 + t2;
		end
		chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
		chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
	endfunction

	// Append the 0x80 marker, zero fill and the bit length, compressing one or two blocks
	function void pad_and_close();
		logic [63:0] bit_len;
		int lane, wi, l, i;
		lane = int'(blk_fill[1:0]);
		wi   = int'(blk_fill[5:2]);
		for (l = lane; l < 4; l++)
			msg_blk[wi][8*(3-l) +: 8] = 8'h00;
		msg_blk[wi][8*(3-lane) +: 8] = 8'h80;
		for (i = wi + 1; i < 16; i++)
			msg_blk[i] = '0;
		if (blk_fill >= 6'd56) begin
			compress_block();
			for (i = 0; i < 16; i++)
				msg_blk[i] = '0;
		end
		bit_len = {byte_count, 3'b000};
		msg_blk[14] = bit_len[63:32];
		msg_blk[15] = bit_len[31:0];
		compress_block();
	endfunction

	// Note one accepted input word and queue the digest it completes, if any
	function void absorb_word(logic [1:0] cmd, logic [7:0] data);
		digest_entry_t ent;
		int k;
		if (cmd == shabs_pkg::CMD_DATA || cmd == shabs_pkg::CMD_LAST) begin
			if (blk_fill[1:0] == 2'd0)
				msg_blk[blk_fill[5:2]] = '0;
			msg_blk[blk_fill[5:2]][8*(3-blk_fill[1:0]) +: 8] = data;
			blk_fill   = blk_fill + 6'd1;
			byte_count = byte_count + 61'd1;
			if (blk_fill == 6'd0)
				compress_block();
		end
		if (cmd == shabs_pkg::CMD_LAST || cmd == shabs_pkg::CMD_END) begin
			pad_and_close();
			for (k = 0; k < 8; k++) begin
				ent.word = chain[k];
				ent.last = (k == 7);
				pending_digest.push_back(ent);
			end
			restart();
		end
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		$display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
		fails++;
	endtask

	task check_digest_word(logic [31:0] data, logic last);
		digest_entry_t ent;
		if (pending_digest.size() == 0) begin
			report("unexpected digest word", data, 32'h0);
		end else begin
			ent = pending_digest.pop_front();
			if (data !== ent.word)
				report("digest word", data, ent.word);
			if (last !== ent.last)
				report("last flag", {31'h0, last}, {31'h0, ent.last});
		end
	endtask

	function int pending_count();
		return pending_digest.size();
	endfunction
endclass

module testbench;
	import shabs_pkg::*;

	// Code 3 is outside the command set; the hasher must drop it
	localparam logic [1:0] CMD_SPARE   = 2'd3;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         ITEM_TARGET = 230;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = 8'h00;   // [7:0] data_byte
	logic [1:0]  s_tuser  = CMD_DATA; // [1:0] command
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;            // [31:0] digest_word
	logic        m_tlast;            // last_word

	digest_scoreboard sb;
	int  cycle_count = 0;
	int  rx_hold     = 0;
	bit  rx_quiet    = 1'b0;
	bit  quiet_sender;
	int  sent;

	sha256_byte_stream_hasher i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly no gap or a short one, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	// Receiver: random stalls, with stretches of steady ready
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else if (!rx_quiet && $urandom_range(0, 3) == 0) begin
			m_tready <= 1'b0;
			rx_hold  <= pick_gap();
		end else begin
			m_tready <= 1'b1;
		end
		if ($urandom_range(0, 149) == 0)
			rx_quiet <= !rx_quiet;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_digest_word(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Offer one word, hold it until accepted, then note it; called at a rising edge
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] data);
		int gap;
		gap = quiet_sender ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= data;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.absorb_word(cmd, data);
		if (cmd != CMD_SPARE)
			sent++;
	endtask

	// Hold off the sender until every queued digest word has left
	task automatic drain_digests();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
	endtask

	task automatic send_message(input int len, input bit end_with_last);
		int k;
		for (k = 0; k < len; k++) begin
			if ($urandom_range(0, 39) == 0)
				send_word(CMD_SPARE, 8'($urandom));
			if (end_with_last && k == len - 1)
				send_word(CMD_LAST, 8'($urandom_range(0, 255)));
			else
				send_word(CMD_DATA, 8'($urandom_range(0, 255)));
		end
		if (!end_with_last)
			send_word(CMD_END, 8'($urandom_range(0, 255)));
	endtask

	initial begin
		int r, len;
		bit use_last;
		sb = new();
		sent = 0;
		quiet_sender = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty message, a lone final byte of all ones
		send_word(CMD_END, 8'h00);
		send_word(CMD_LAST, 8'hFF);
		// Spare code dropped between bytes, message closed by an end without a byte
		send_word(CMD_SPARE, 8'h5A);
		send_word(CMD_DATA, 8'h00);
		send_word(CMD_SPARE, 8'hFF);
		send_word(CMD_DATA, 8'h80);
		send_word(CMD_END, 8'hFF);
		// The classic three-letter message
		send_word(CMD_DATA, 8'h61);
		send_word(CMD_DATA, 8'h62);
		send_word(CMD_LAST, 8'h63);
		drain_digests();
		send_word(CMD_LAST, 8'h00);

		// Random messages; lengths cluster around the one- and two-block padding edges
		while (sent < ITEM_TARGET) begin
			quiet_sender = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < 55)
				len = $urandom_range(0, 12);
			else if (r < 85)
				len = $urandom_range(52, 66);
			else
				len = $urandom_range(100, 130);
			use_last = (len != 0) && ($urandom_range(0, 9) < 7);
			send_message(len, use_last);
			if ($urandom_range(0, 9) == 0)
				drain_digests();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (sb.pending_count() != 0) @(posedge clk);
		// Catch stray words: allow well over one compression after the last digest
		repeat (200) @(posedge clk);
		if (sb.fails == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end
endmodule
